// ===== hw/rtl/smeu_pkg.sv =====
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and constants
// Opcodes, controller command and status structs for the execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [3:0] {
        OP_POP    = 4'd0,
        OP_PUSH   = 4'd1,
        OP_DUP    = 4'd2,
        OP_ADD    = 4'd3,
        OP_SUB    = 4'd4,
        OP_MUL    = 4'd5,
        OP_DIV    = 4'd6,
        OP_SWAP   = 4'd7,
        OP_PRINT  = 4'd8,
        OP_PRINTC = 4'd9,
        OP_NOP    = 4'd10,
        OP_HALT   = 4'd11,
        OP_INC    = 4'd12,
        OP_DEC    = 4'd13,
        OP_BAD0   = 4'd14,
        OP_BAD1   = 4'd15
    } t_op;

    // what the datapath should do this cycle
    typedef enum logic [3:0] {
        CMD_IDLE  = 4'd0,
        CMD_LOAD  = 4'd1,  // latch instruction, start reading top
        CMD_RD2   = 4'd2,  // read next word
        CMD_EXEC  = 4'd3,  // both operands valid: compute
        CMD_DIVST = 4'd4,  // one divide step
        CMD_WB    = 4'd5,  // write first result word
        CMD_WB2   = 4'd6,  // write second result word (swap)
        CMD_PRD   = 4'd7,  // issue a print read
        CMD_EMIT  = 4'd8   // emit a status-only result
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic div_done;
        logic prt_last;
    } t_sts;

endpackage

// ===== hw/rtl/smeu_ram.sv =====
// ----------------------------------------------------------------------------
// smeu_ram: generic single-port RAM
// One address a cycle, written when i_we is high and read every cycle; registered read data.
// ----------------------------------------------------------------------------
module smeu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/smeu_ctrl.sv =====
// ----------------------------------------------------------------------------
// smeu_ctrl: instruction sequencer
// Decodes the opcode against the stack count and steps the datapath.
// ----------------------------------------------------------------------------
module smeu_ctrl
    import smeu_pkg::*;
#(
    parameter int unsigned CNT_W = 5,
    parameter int unsigned DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [3:0]       i_func,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_zero_next,
    input  t_sts             i_sts,
    output t_ctl             o_ctl,
    output logic             o_busy
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD1   = 10'b0000000010,
        S_RD2   = 10'b0000000100,
        S_EXEC  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_WB    = 10'b0000100000,
        S_WB2   = 10'b0001000000,
        S_PRINT = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_PWAIT = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic fewer1, fewer2;
    assign fewer1 = (i_count == '0);
    assign fewer2 = (i_count < CNT_W'(2));

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_ctl.cmd = CMD_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = t_op'(i_func);
                    o_ctl.cmd = CMD_LOAD;
                    n_state = S_EMIT;
                    unique case (t_op'(i_func))
                        OP_PUSH:  if (i_count != FULL) n_state = S_WB;
                        OP_DUP, OP_INC, OP_DEC, OP_PRINTC:
                            if (!fewer1 && !(t_op'(i_func) == OP_DUP && i_count == FULL))
                                n_state = S_RD1;
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP:
                            if (!fewer2) n_state = S_RD1;
                        OP_PRINT: if (!fewer1) n_state = S_PRINT;
                        default: ;
                    endcase
                end
            end
            S_RD1: begin
                o_ctl.cmd = CMD_RD2;
                n_state = (r_op == OP_DUP || r_op == OP_INC || r_op == OP_DEC
                           || r_op == OP_PRINTC) ? S_EXEC : S_RD2;
            end
            S_RD2: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.cmd = CMD_EXEC;
                priority if (r_op == OP_PRINTC) n_state = S_IDLE;
                else if (r_op == OP_DIV && i_zero_next) n_state = S_IDLE;
                else if (r_op == OP_DIV) n_state = S_DIV;
                else n_state = S_WB;
            end
            S_DIV: begin
                o_ctl.cmd = CMD_DIVST;
                if (i_sts.div_done) n_state = S_WB;
            end
            S_WB: begin
                o_ctl.cmd = CMD_WB;
                n_state = (r_op == OP_SWAP) ? S_WB2 : S_IDLE;
            end
            S_WB2: begin
                o_ctl.cmd = CMD_WB2;
                n_state = S_IDLE;
            end
            S_PRINT: begin
                o_ctl.cmd = CMD_PRD;
                n_state = S_PWAIT;
            end
            S_PWAIT: begin
                n_state = i_sts.prt_last ? S_IDLE : S_PWAIT;
                if (!i_sts.prt_last) o_ctl.cmd = CMD_PRD;
            end
            S_EMIT: begin
                o_ctl.cmd = CMD_EMIT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op <= n_op;
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== hw/rtl/smeu_dp.sv =====
// ----------------------------------------------------------------------------
// smeu_dp: stack datapath
// Stack RAM, count, operand registers, ALU, restoring divider, result beat.
// ----------------------------------------------------------------------------
module smeu_dp
    import smeu_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned CNT_W = 5,
    parameter int unsigned ADR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [3:0]        i_func,
    input  logic [WORD_W-1:0] i_push_value,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_zero_next,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic              o_ok,
    output logic              o_has_value,
    output logic [WORD_W-1:0] o_value,
    output logic              o_as_char,
    output logic              o_last
);
    logic [CNT_W-1:0]  r_count, n_count;
    t_op               r_op;
    logic [WORD_W-1:0] r_imm, r_a, r_b, r_res;
    // divider: r_a numerator shifted into quotient, r_rem partial remainder
    logic [WORD_W-1:0] r_rem;
    logic [5:0]        r_dcnt;
    logic [CNT_W-1:0]  r_pidx;      // next print address
    logic [CNT_W-1:0]  r_pout;      // index of word due out
    logic              r_pv1;       // print read in flight
    logic              r_rd_a;      // RAM data this cycle is the top
    logic              r_rd_b;

    // result beat registers
    logic              r_valid, r_hv, r_ch, r_last, r_rok;
    logic [WORD_W-1:0] r_val;

    logic              ram_we;
    logic [ADR_W-1:0]  ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    smeu_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic [CNT_W-1:0] top_i, nxt_i;
    assign top_i = r_count - CNT_W'(1);
    assign nxt_i = r_count - CNT_W'(2);

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = top_i[ADR_W-1:0];
        ram_wdata = r_res;
        n_count   = r_count;
        unique case (i_ctl.cmd)
            CMD_RD2:  ram_addr = nxt_i[ADR_W-1:0];
            CMD_PRD:  ram_addr = r_pidx[ADR_W-1:0];
            CMD_WB: begin
                ram_we = 1'b1;
                unique case (r_op)
                    OP_PUSH: begin
                        ram_addr = r_count[ADR_W-1:0]; ram_wdata = r_imm;
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_DUP: begin
                        ram_addr = r_count[ADR_W-1:0];
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_INC, OP_DEC: ram_addr = top_i[ADR_W-1:0];
                    OP_SWAP: begin
                        ram_addr = top_i[ADR_W-1:0]; ram_wdata = r_b;
                    end
                    default: begin
                        ram_addr = nxt_i[ADR_W-1:0];
                        n_count = r_count - CNT_W'(1);
                    end
                endcase
            end
            CMD_WB2: begin
                ram_we = 1'b1; ram_addr = nxt_i[ADR_W-1:0]; ram_wdata = r_a;
            end
            default: ;
        endcase
        if (i_ctl.cmd == CMD_EXEC && r_op == OP_POP) n_count = r_count;
    end

    logic [WORD_W:0] trial;
    assign trial = {r_rem, r_a[WORD_W-1]} - {1'b0, r_b};

    logic [2*WORD_W-1:0] prod;
    assign prod = r_a * r_b;

    always_ff @(posedge i_clk) begin
        r_rd_a <= (i_ctl.cmd == CMD_LOAD);
        r_rd_b <= (i_ctl.cmd == CMD_RD2);
        r_pv1  <= (i_ctl.cmd == CMD_PRD);
        r_valid <= 1'b0;
        // operand capture
        if (r_rd_a) r_a <= ram_rdata;
        if (r_rd_b) r_b <= ram_rdata;
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                r_op   <= t_op'(i_func);
                r_imm  <= i_push_value;
                r_pidx <= '0;
                r_pout <= '0;
                r_dcnt <= '0;
                r_rem  <= '0;
            end
            CMD_EXEC: begin
                unique case (r_op)
                    OP_ADD:  r_res <= r_a + r_b;
                    OP_SUB:  r_res <= r_a - r_b;
                    OP_MUL:  r_res <= prod[WORD_W-1:0];
                    OP_INC:  r_res <= r_a + WORD_W'(1);
                    OP_DEC:  r_res <= r_a - WORD_W'(1);
                    default: r_res <= r_a;
                endcase
                if (r_op == OP_PRINTC) begin
                    r_valid <= 1'b1; r_rok <= 1'b1; r_hv <= 1'b1; r_ch <= 1'b1;
                    r_last <= 1'b1; r_val <= {{(WORD_W-8){1'b0}}, r_a[7:0]};
                end else if (r_op == OP_DIV && r_b == '0) begin
                    r_valid <= 1'b1; r_rok <= 1'b0; r_hv <= 1'b0; r_ch <= 1'b0;
                    r_last <= 1'b1; r_val <= '0;
                end
            end
            CMD_DIVST: begin
                if (!trial[WORD_W]) r_rem <= trial[WORD_W-1:0];
                else r_rem <= {r_rem[WORD_W-2:0], r_a[WORD_W-1]};
                r_a    <= {r_a[WORD_W-2:0], ~trial[WORD_W]};
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'(WORD_W-1))
                    r_res <= {r_a[WORD_W-2:0], ~trial[WORD_W]};
            end
            CMD_PRD: r_pidx <= r_pidx + CNT_W'(1);
            default: ;
        endcase
        if (i_ctl.cmd == CMD_WB && r_op != OP_SWAP) begin
            r_valid <= 1'b1; r_rok <= 1'b1; r_hv <= 1'b0; r_ch <= 1'b0;
            r_last <= 1'b1; r_val <= '0;
        end
        if (i_ctl.cmd == CMD_WB2) begin
            r_valid <= 1'b1; r_rok <= 1'b1; r_hv <= 1'b0; r_ch <= 1'b0;
            r_last <= 1'b1; r_val <= '0;
        end
        if (i_ctl.cmd == CMD_EMIT) begin
            r_valid <= 1'b1;
            r_rok <= (r_op == OP_NOP || r_op == OP_HALT
                      || (r_op == OP_POP && r_count != '0));
            r_hv <= 1'b0; r_ch <= 1'b0; r_last <= 1'b1; r_val <= '0;
        end
        // print beat, one per stack word
        if (r_pv1) begin
            r_valid <= 1'b1; r_rok <= 1'b1; r_hv <= 1'b1; r_ch <= 1'b0;
            r_val <= ram_rdata;
            r_last <= (r_pout == top_i);
            r_pout <= r_pout + CNT_W'(1);
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else if (i_ctl.cmd == CMD_EMIT && r_op == OP_POP && r_count != '0) begin
            r_count <= r_count - CNT_W'(1);
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count        = r_count;
    assign o_zero_next    = (r_b == '0);
    assign o_sts.div_done = (r_dcnt == 6'(WORD_W-1));
    assign o_sts.prt_last = (r_pidx == r_count);
    assign o_valid        = r_valid;
    assign o_ok           = r_rok;
    assign o_has_value    = r_hv;
    assign o_value        = r_val;
    assign o_as_char      = r_ch;
    assign o_last         = r_last;
endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit: stack-machine instruction executor
// Sequencer plus datapath over a STACK_DEPTH word stack held in RAM.
// ----------------------------------------------------------------------------
// One instruction is taken when start is high and busy low. Results come
// out one beat per cycle on o_valid and cannot be held off. Pop, nop, halt
// and operand-count failures go straight to a status beat, push writes the
// new word; print-char reads the top, dup, inc and dec read it and write back,
// binary ops read two words and write one (a divide by zero fails before the
// divider runs), swap writes both; divide runs its bit-serial divider. Print
// makes one RAM read per word through the single stack RAM port.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        i_func,
    input  logic [WORD_W-1:0] i_push_value,
    output logic              o_valid,
    output logic              o_ok,
    output logic              o_has_value,
    output logic [WORD_W-1:0] o_value,
    output logic              o_as_char,
    output logic              o_last
);
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADR_W = $clog2(STACK_DEPTH);

    t_ctl             ctl;
    t_sts             sts;
    logic [CNT_W-1:0] count;
    logic             zero_next, ctl_busy;

    smeu_ctrl #(.CNT_W(CNT_W), .DEPTH(STACK_DEPTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_func),
        .i_count(count), .i_zero_next(zero_next), .i_sts(sts),
        .o_ctl(ctl), .o_busy(ctl_busy)
    );

    smeu_dp #(.DEPTH(STACK_DEPTH), .CNT_W(CNT_W), .ADR_W(ADR_W)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_func(i_func),
        .i_push_value(i_push_value), .o_count(count), .o_zero_next(zero_next),
        .o_sts(sts), .o_valid(o_valid), .o_ok(o_ok), .o_has_value(o_has_value),
        .o_value(o_value), .o_as_char(o_as_char), .o_last(o_last)
    );

    // the last result beat may still be out while the next start is taken
    assign busy = ctl_busy;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(STACK_DEPTH)) else $error("stack count beyond depth");
    a_char_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_as_char |-> o_value[WORD_W-1:8] == '0 && o_has_value)
        else $error("printc value wider than a byte");
    a_fail_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_last && !o_has_value)
        else $error("failure beat carries a value");
`endif
endmodule

// ===== bench/tb_stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tb_stack_machine_execute_unit: self-checking bench for the execute unit
// A directed table runs the edge cases (empty, divide by zero, bad opcodes,
// print), a fill to full, then random instruction streams. The bench predicts
// every result beat and checks each one as it is strobed out.
// ----------------------------------------------------------------------------
module tb_stack_machine_execute_unit
    import smeu_pkg::*;
();

    localparam int unsigned DEPTH    = 16;
    localparam int unsigned N_RANDOM = 120;
    localparam int unsigned WDOG_MAX = 2000;

    typedef struct packed {
        logic        ok;
        logic        has_value;
        logic [31:0] value;
        logic        as_char;
        logic        last;
    } t_beat;

    typedef struct {
        t_op         op;
        logic [31:0] imm;
        logic        chk;   // typed-in expectation present
        logic        ok;    // expected ok of single-beat result
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [3:0]        i_func;
    logic [31:0]       i_push_value;
    logic              o_valid;
    logic              o_ok;
    logic              o_has_value;
    logic [31:0]       o_value;
    logic              o_as_char;
    logic              o_last;

    t_beat       beats_due[$];
    logic [31:0] stk[DEPTH];
    int unsigned stk_n;
    int unsigned errors;
    int unsigned idle_cycles;
    logic        accepted;
    logic        done;

    stack_machine_execute_unit #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_has_value  (o_has_value),
        .o_value      (o_value),
        .o_as_char    (o_as_char),
        .o_last       (o_last)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // status-only beat
    function automatic t_beat status_beat(input logic ok);
        t_beat b;
        b = '0;
        b.ok = ok;
        b.last = 1'b1;
        return b;
    endfunction

    // work out the beats of one instruction and advance the stack copy
    task automatic execute_op(input t_op op, input logic [31:0] imm);
        logic [31:0] top, nxt;
        logic        ok;
        t_beat       b;
        ok = 1'b0;
        top = (stk_n >= 1) ? stk[stk_n-1] : '0;
        nxt = (stk_n >= 2) ? stk[stk_n-2] : '0;
        case (op)
            OP_POP: if (stk_n >= 1) begin
                stk_n--; ok = 1'b1;
            end
            OP_PUSH: if (stk_n < DEPTH) begin
                stk[stk_n] = imm; stk_n++; ok = 1'b1;
            end
            OP_DUP: if (stk_n >= 1 && stk_n < DEPTH) begin
                stk[stk_n] = top; stk_n++; ok = 1'b1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (stk_n >= 2 &&
                    !(op == OP_DIV && nxt == 0)) begin
                case (op)
                    OP_ADD:  stk[stk_n-2] = top + nxt;
                    OP_SUB:  stk[stk_n-2] = top - nxt;
                    OP_MUL:  stk[stk_n-2] = top * nxt;
                    default: stk[stk_n-2] = top / nxt;
                endcase
                stk_n--; ok = 1'b1;
            end
            OP_SWAP: if (stk_n >= 2) begin
                stk[stk_n-1] = nxt; stk[stk_n-2] = top; ok = 1'b1;
            end
            OP_PRINT: if (stk_n >= 1) begin
                for (int unsigned i = 0; i < stk_n; i++) begin
                    b = '{1'b1, 1'b1, stk[i], 1'b0, (i + 1 == stk_n)};
                    beats_due.push_back(b);
                end
                return;
            end
            OP_PRINTC: if (stk_n >= 1) begin
                b = '{1'b1, 1'b1, {24'd0, top[7:0]}, 1'b1, 1'b1};
                beats_due.push_back(b);
                return;
            end
            OP_NOP, OP_HALT: ok = 1'b1;
            OP_INC: if (stk_n >= 1) begin
                stk[stk_n-1] = top + 1; ok = 1'b1;
            end
            OP_DEC: if (stk_n >= 1) begin
                stk[stk_n-1] = top - 1; ok = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        beats_due.push_back(status_beat(ok));
    endtask

    // drive one beat: optional gap with start low, then hold start until
    // accepted; returns at the falling edge after the accept
    task automatic issue_op(input t_op op, input logic [31:0] imm, input int gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= op;
        i_push_value <= imm;
        do @(posedge i_clk); while (busy);
        execute_op(op, imm);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_beat got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_ok, o_has_value, o_value, o_as_char, o_last};
            if (beats_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
            end else begin
                want = beats_due.pop_front();
                if (got.ok !== want.ok || got.has_value !== want.has_value ||
                    got.value !== want.value || got.as_char !== want.as_char ||
                    got.last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch, expected ok=%b hv=%b val=%h ch=%b last=%b",
                             $time, want.ok, want.has_value, want.value,
                             want.as_char, want.last);
                    $display("%0t:           actual   ok=%b hv=%b val=%h ch=%b last=%b",
                             $time, got.ok, got.has_value, got.value,
                             got.as_char, got.last);
                end
            end
        end
    end

    // watchdog: cycles with no beat in either direction
    assign accepted = (start && !busy) || o_valid;
    always @(posedge i_clk) begin
        if (!i_rst_n || accepted) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (!done && idle_cycles >= WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row        rows[$];
        t_op         op;
        logic [31:0] imm;
        int unsigned r, cnt;
        errors = 0; idle_cycles = 0; stk_n = 0; done = 1'b0;
        i_rst_n = 1'b0; start = 1'b0; i_func = '0; i_push_value = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: empty-stack failures, extremes, every opcode
        rows = '{
            '{OP_POP,    32'h0,        1, 0}, '{OP_DUP,    32'h0,        1, 0},
            '{OP_ADD,    32'h0,        1, 0}, '{OP_PRINT,  32'h0,        1, 0},
            '{OP_PRINTC, 32'h0,        1, 0}, '{OP_INC,    32'h0,        1, 0},
            '{OP_BAD0,   32'h0,        1, 0}, '{OP_BAD1,   32'h0,        1, 0},
            '{OP_NOP,    32'h0,        1, 1}, '{OP_HALT,   32'h0,        1, 1},
            '{OP_PUSH,   32'h0,        1, 1}, '{OP_SWAP,   32'h0,        1, 0},
            '{OP_PUSH,   32'hFFFFFFFF, 1, 1}, '{OP_DIV,    32'h0,        1, 0},
            '{OP_SWAP,   32'h0,        0, 0}, '{OP_DIV,    32'h0,        0, 0},
            '{OP_INC,    32'h0,        0, 0}, '{OP_PUSH,   32'h80000041, 0, 0},
            '{OP_PRINTC, 32'h0,        0, 0}, '{OP_MUL,    32'h0,        0, 0},
            '{OP_DUP,    32'h0,        0, 0}, '{OP_SUB,    32'h0,        0, 0},
            '{OP_DEC,    32'h0,        0, 0}, '{OP_PRINT,  32'h0,        0, 0}
        };
        foreach (rows[k]) begin
            issue_op(rows[k].op, rows[k].imm, $urandom_range(0, 6));
            // typed-in rows give a single status beat, still queued here
            if (rows[k].chk && (beats_due.size() == 0 ||
                                beats_due[$] !== status_beat(rows[k].ok))) begin
                errors++;
                $display("%0t: row %0d expected %h, actual %h", $time, k,
                         status_beat(rows[k].ok), beats_due[$]);
            end
        end

        // fill to full, overflow push and dup, print the whole stack
        while (stk_n < DEPTH) issue_op(OP_PUSH, $urandom, 0);
        issue_op(OP_PUSH, 32'hA5A5A5A5, 0);
        issue_op(OP_DUP, 32'h0, 1);
        issue_op(OP_PRINT, 32'h0, 0);
        start <= 1'b0;

        // sender holds off until all beats have drained
        while (beats_due.size() != 0) @(negedge i_clk);

        // random part: mostly operations that keep the stack mid-depth
        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8) op = t_op'($urandom_range(0, 15));
            else if (stk_n < 3 && r < 60) op = OP_PUSH;
            else if (stk_n > DEPTH - 2 && r < 50) op = OP_POP;
            else op = t_op'($urandom_range(0, 13));
            case ($urandom_range(0, 3))
                0:       imm = $urandom_range(0, 3);
                1:       imm = 32'hFFFFFFFF - $urandom_range(0, 3);
                default: imm = $urandom;
            endcase
            issue_op(op, imm, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
        end
        start <= 1'b0;

        // drain, then a short tail for stray beats
        cnt = 0;
        while (beats_due.size() != 0 && cnt < WDOG_MAX) begin
            @(negedge i_clk);
            cnt++;
        end
        done = 1'b1;
        repeat (60) @(negedge i_clk);
        if (errors == 0 && beats_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
